// File: rtl/dnis_pkg.sv
// Package for the directional nearest item selector.
// Holds the direction codes, constants and the direction unit vector table.
// No dependencies.
package dnis_pkg;

    // Q12 unit vector components
    localparam logic signed [13:0] UNIT_POS = 14'sd4096;
    localparam logic signed [13:0] UNIT_NEG = -14'sd4096;
    localparam logic signed [13:0] DIAG_POS = 14'sd2896;
    localparam logic signed [13:0] DIAG_NEG = -14'sd2896;

    // Numerator of the inverse distance
    localparam logic [31:0] INV_NUM = 32'h0100_0000;

    // Direction codes
    localparam logic [3:0] DIR_UP    = 4'd2;
    localparam logic [3:0] DIR_DOWN  = 4'd3;
    localparam logic [3:0] DIR_LEFT  = 4'd4;
    localparam logic [3:0] DIR_RIGHT = 4'd5;
    localparam logic [3:0] DIR_DG6   = 4'd6;
    localparam logic [3:0] DIR_DG7   = 4'd7;
    localparam logic [3:0] DIR_DG8   = 4'd8;
    localparam logic [3:0] DIR_DG9   = 4'd9;

    typedef logic signed [13:0] vec_comp_t;

    // x component of the direction's unit vector
    function automatic vec_comp_t dir_ux(input logic [3:0] dir);
        vec_comp_t u;
        case (dir)
            DIR_LEFT:  u = UNIT_NEG;
            DIR_RIGHT: u = UNIT_POS;
            DIR_DG6:   u = DIAG_POS;
            DIR_DG7:   u = DIAG_NEG;
            DIR_DG8:   u = DIAG_POS;
            DIR_DG9:   u = DIAG_NEG;
            default:   u = '0;
        endcase
        return u;
    endfunction

    // y component of the direction's unit vector
    function automatic vec_comp_t dir_uy(input logic [3:0] dir);
        vec_comp_t u;
        case (dir)
            DIR_UP:   u = UNIT_NEG;
            DIR_DOWN: u = UNIT_POS;
            DIR_DG6:  u = DIAG_NEG;
            DIR_DG7:  u = DIAG_NEG;
            DIR_DG8:  u = DIAG_POS;
            DIR_DG9:  u = DIAG_POS;
            default:  u = '0;
        endcase
        return u;
    endfunction

endpackage

// File: rtl/directional_nearest_item_select.sv
// Directional nearest item selector, top level.
// Depends on dnis_pkg for direction vectors and constants.
//
// Usage:
// Menu items enter on the s_axis channel, one per transaction. s_axis_tuser
// marks the first item of a search, s_axis_tlast the last one. Each item is
// scored against the cursor point and the direction code; the best score of
// the search is kept. After the last item one result leaves on m_axis:
// m_axis_tuser is the found flag, tdata carries winner index and score.
// Flow control: one item at a time; s_axis_tready is high only while idle. A
// skipped item goes from idle straight to the finish state. A zero distance
// leaves after the bit-serial root, a negative dot product after the shared
// bit-serial divider has run three times (x, y, inverse), and a scored item
// also passes the score and compare states. The result is registered when
// the last item reaches the finish state and the output register is free.
// The result register is separate from the input side: a waiting result
// does not stop the next search; only a second result waits until the
// first is taken. Reset clears the running best and empties the output.
module directional_nearest_item_select
    import dnis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_x[14:0], center_y[29:15], item_index[35:30], is_selectable[36],
    // is_current[37], cursor_x[52:38], cursor_y[67:53], move_dir[71:68]
    input  logic [71:0] s_axis_tdata,
    // first_item[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // winner_index[5:0], winner_score[37:6], zero pad[39:38]
    output logic [39:0] m_axis_tdata,
    // found[0]
    output logic        m_axis_tuser
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;
    localparam logic [3:0] ST_SQY   = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_DIVX  = 4'd4;
    localparam logic [3:0] ST_DIVY  = 4'd5;
    localparam logic [3:0] ST_DIVI  = 4'd6;
    localparam logic [3:0] ST_DOTX  = 4'd7;
    localparam logic [3:0] ST_DOTY  = 4'd8;
    localparam logic [3:0] ST_SQD   = 4'd9;
    localparam logic [3:0] ST_SCORE = 4'd10;
    localparam logic [3:0] ST_CMP   = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic               last_reg, last_next;
    logic [5:0]         idx_reg, idx_next;
    logic [3:0]         dir_reg, dir_next;
    logic signed [15:0] dx_reg, dx_next;
    logic signed [15:0] dy_reg, dy_next;
    logic [31:0]        sq_reg, sq_next;
    logic [17:0]        rrem_reg, rrem_next;
    logic [15:0]        root_reg, root_next;
    logic [15:0]        drem_reg, drem_next;
    logic [31:0]        dq_reg, dq_next;
    logic signed [13:0] nx_reg, nx_next;
    logic signed [13:0] ny_reg, ny_next;
    logic [24:0]        inv_reg, inv_next;
    logic signed [15:0] termx_reg, termx_next;
    logic signed [14:0] dot_reg, dot_next;
    logic [14:0]        sqd_reg, sqd_next;
    logic [31:0]        score_reg, score_next;
    logic [31:0]        best_score_reg, best_score_next;
    logic [5:0]         best_index_reg, best_index_next;
    logic               have_best_reg, have_best_next;
    logic               ovalid_reg, ovalid_next;
    logic               ofound_reg, ofound_next;
    logic [5:0]         oidx_reg, oidx_next;
    logic [31:0]        oscore_reg, oscore_next;

    logic               s_fire;
    logic signed [15:0] in_dx, in_dy;
    logic               in_eligible;
    logic signed [15:0] sq_op;
    logic [31:0]        sq_prod;
    logic [19:0]        root_trial_rem;
    logic [19:0]        root_trial;
    logic [16:0]        div_rem2;
    logic               div_ge;
    logic [16:0]        div_diff;
    logic [15:0]        abs_dy;
    logic signed [13:0] dot_u, dot_n;
    logic signed [27:0] dot_prod;
    logic signed [15:0] dot_term;
    logic [27:0]        dsq_prod;
    logic [39:0]        score_prod;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Field differences and eligibility of the incoming item
    assign in_dx = 16'(signed'(s_axis_tdata[14:0])) - 16'(signed'(s_axis_tdata[52:38]));
    assign in_dy = 16'(signed'(s_axis_tdata[29:15])) - 16'(signed'(s_axis_tdata[67:53]));
    assign in_eligible = s_axis_tdata[36] && !s_axis_tdata[37]
                         && (s_axis_tdata[71:68] inside {[DIR_UP:DIR_DG9]});

    // Squares, one axis per cycle
    assign sq_op   = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign sq_prod = 32'(sq_op * sq_op);

    // Root step: two radicand bits per cycle
    assign root_trial_rem = {rrem_reg, sq_reg[31:30]};
    assign root_trial     = {2'b00, root_reg, 2'b01};

    // Divider step: one quotient bit per cycle, divisor is the root
    assign div_rem2 = {drem_reg, dq_reg[31]};
    assign div_ge   = (div_rem2 >= {1'b0, root_reg});
    assign div_diff = div_rem2 - {1'b0, root_reg};
    assign abs_dy   = dy_reg[15] ? 16'(-dy_reg) : dy_reg;

    // Dot product term, one axis per cycle, floor shift by 12
    assign dot_u    = (state_reg == ST_DOTX) ? dir_ux(dir_reg) : dir_uy(dir_reg);
    assign dot_n    = (state_reg == ST_DOTX) ? nx_reg : ny_reg;
    assign dot_prod = dot_u * dot_n;
    assign dot_term = dot_prod[27:12];

    assign dsq_prod   = 28'(dot_reg[13:0] * dot_reg[13:0]);
    assign score_prod = inv_reg * {10'd0, sqd_reg};

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        dir_next        = dir_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sq_next         = sq_reg;
        rrem_next       = rrem_reg;
        root_next       = root_reg;
        drem_next       = drem_reg;
        dq_next         = dq_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        inv_next        = inv_reg;
        termx_next      = termx_reg;
        dot_next        = dot_reg;
        sqd_next        = sqd_reg;
        score_next      = score_reg;
        best_score_next = best_score_reg;
        best_index_next = best_index_reg;
        have_best_next  = have_best_reg;
        ovalid_next     = ovalid_reg && !m_axis_tready;
        ofound_next     = ofound_reg;
        oidx_next       = oidx_reg;
        oscore_next     = oscore_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    last_next = s_axis_tlast;
                    idx_next  = s_axis_tdata[35:30];
                    dir_next  = s_axis_tdata[71:68];
                    dx_next   = in_dx;
                    dy_next   = in_dy;
                    if (s_axis_tuser)
                    begin
                        best_score_next = '0;
                        best_index_next = '0;
                        have_best_next  = 1'b0;
                    end
                    state_next = in_eligible ? ST_SQX : ST_FIN;
                end
            end
            ST_SQX:
            begin
                sq_next    = sq_prod;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                sq_next    = sq_reg + sq_prod;
                rrem_next  = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                sq_next = {sq_reg[29:0], 2'b00};
                if (root_trial_rem >= root_trial)
                begin
                    rrem_next = 18'(root_trial_rem - root_trial);
                    root_next = {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rrem_next = root_trial_rem[17:0];
                    root_next = {root_reg[14:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd15)
                begin
                    step_next = '0;
                    drem_next = '0;
                    dq_next   = {4'd0, (dx_reg[15] ? 16'(-dx_reg) : dx_reg), 12'd0};
                    // zero distance: skipped
                    if (root_next == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_DIVX;
                end
            end
            ST_DIVX, ST_DIVY, ST_DIVI:
            begin
                drem_next = div_ge ? div_diff[15:0] : div_rem2[15:0];
                dq_next   = {dq_reg[30:0], div_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    drem_next = '0;
                    case (state_reg)
                        ST_DIVX:
                        begin
                            nx_next    = ((dx_reg[15]) ? 14'(-{1'b0, dq_next[12:0]})
                                                       : {1'b0, dq_next[12:0]});
                            dq_next    = {4'd0, abs_dy, 12'd0};
                            state_next = ST_DIVY;
                        end
                        ST_DIVY:
                        begin
                            ny_next    = ((dy_reg[15]) ? 14'(-{1'b0, dq_next[12:0]})
                                                       : {1'b0, dq_next[12:0]});
                            dq_next    = INV_NUM;
                            state_next = ST_DIVI;
                        end
                        default:
                        begin
                            inv_next   = dq_next[24:0];
                            state_next = ST_DOTX;
                        end
                    endcase
                end
            end
            ST_DOTX:
            begin
                termx_next = dot_term;
                state_next = ST_DOTY;
            end
            ST_DOTY:
            begin
                dot_next   = 15'(termx_reg + dot_term);
                state_next = ST_SQD;
            end
            ST_SQD:
            begin
                sqd_next   = dsq_prod[26:12];
                // negative dot: pointing away, skipped
                state_next = dot_reg[14] ? ST_FIN : ST_SCORE;
            end
            ST_SCORE:
            begin
                score_next = {4'd0, score_prod[39:12]};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if ($signed(best_score_reg) < $signed(score_reg))
                begin
                    best_score_next = score_reg;
                    best_index_next = idx_reg;
                    have_best_next  = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next     = 1'b1;
                    ofound_next     = have_best_reg;
                    oidx_next       = have_best_reg ? best_index_reg : '0;
                    oscore_next     = have_best_reg ? best_score_reg : '0;
                    best_score_next = '0;
                    best_index_next = '0;
                    have_best_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            best_score_reg <= '0;
            best_index_reg <= '0;
            have_best_reg  <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            best_score_reg <= best_score_next;
            best_index_reg <= best_index_next;
            have_best_reg  <= have_best_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        dir_reg    <= dir_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sq_reg     <= sq_next;
        rrem_reg   <= rrem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        dq_reg     <= dq_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        inv_reg    <= inv_next;
        termx_reg  <= termx_next;
        dot_reg    <= dot_next;
        sqd_reg    <= sqd_next;
        score_reg  <= score_next;
        ofound_reg <= ofound_next;
        oidx_reg   <= oidx_next;
        oscore_reg <= oscore_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ofound_reg;
    assign m_axis_tdata  = {2'b00, oscore_reg, oidx_reg};

`ifndef SYNTHESIS
    // An accepted item always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // An empty result carries zero index and score
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty result with nonzero payload");

    // A winner always has a positive signed score
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (!m_axis_tdata[37] && (m_axis_tdata[37:6] != '0)))
        else $error("winner with non-positive score");

    // The root never takes more than sixteen steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (step_reg <= 5'd15))
        else $error("root step count overrun");
`endif

endmodule

// File: bench/directional_nearest_item_select_test.sv
// Self-checking testbench for directional_nearest_item_select.
// Scores menu items against a cursor and a direction and compares each search result.
// Depends on dnis_pkg and the directional_nearest_item_select RTL.
module directional_nearest_item_select_test;
    import dnis_pkg::*;

    typedef struct packed {
        logic [3:0]         move_dir;
        logic signed [14:0] cursor_y;
        logic signed [14:0] cursor_x;
        logic               is_current;
        logic               is_selectable;
        logic [5:0]         item_index;
        logic signed [14:0] center_y;
        logic signed [14:0] center_x;
    } menu_item_t;

    typedef struct packed {
        logic        first_item;
        logic        last_item;
        menu_item_t  item;
    } item_txn_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  winner_index;
        logic [31:0] winner_score;
    } pick_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    item_txn_t pending_items[$];
    pick_t     expected_picks[$];

    // running best of the search in progress
    logic [31:0] best_score;
    logic [5:0]  best_index;
    logic        have_best;

    int  mismatches;
    int  src_gap;
    int  sink_gap;
    bit  calm;
    bit  hold_src;
    bit  took_item;

    directional_nearest_item_select DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // score one item and fold it into the running best; may produce a pick
    task automatic score_item(input item_txn_t t);
        int signed   dx, dy, di, nx, ny, ux, uy, dotp;
        logic [31:0] d, sq, sc, inv, sqd;
        logic [63:0] prod;
        menu_item_t  m;
        pick_t       p;
        m = t.item;
        if (t.first_item)
        begin
            best_score = 0;
            best_index = 0;
            have_best  = 0;
        end
        if ((m.move_dir inside {[DIR_UP:DIR_DG9]}) && m.is_selectable && !m.is_current)
        begin
            dx = int'(m.center_x) - int'(m.cursor_x);
            dy = int'(m.center_y) - int'(m.cursor_y);
            sq = 32'(dx * dx) + 32'(dy * dy);
            d  = floor_root(sq);
            if (d != 0)
            begin
                di = int'(d);
                nx = (dx * 4096) / di;
                ny = (dy * 4096) / di;
                ux = int'(dir_ux(m.move_dir));
                uy = int'(dir_uy(m.move_dir));
                dotp = ((ux * nx) >>> 12) + ((uy * ny) >>> 12);
                if (dotp >= 0)
                begin
                    inv  = INV_NUM / d;
                    sqd  = (32'(dotp) * 32'(dotp)) >> 12;
                    prod = (64'(inv) * 64'(sqd)) >> 12;
                    sc   = prod[31:0];
                    if ($signed(best_score) < $signed(sc))
                    begin
                        best_score = sc;
                        best_index = m.item_index;
                        have_best  = 1;
                    end
                end
            end
        end
        if (t.last_item)
        begin
            p = have_best ? pick_t'{1'b1, best_index, best_score}
                          : pick_t'{1'b0, 6'd0, 32'd0};
            expected_picks.insert(expected_picks.size(), p);
            best_score = 0;
            best_index = 0;
            have_best  = 0;
        end
    endtask

    function automatic logic signed [14:0] rand_coord(input logic signed [14:0] base);
        case ($urandom_range(0, 5))
            0: return 15'($urandom);
            1: return base;
            default: return base + 15'(int'($urandom_range(0, 800)) - 400);
        endcase
    endfunction

    task automatic add_item(input menu_item_t m, input logic first_item, input logic last_item);
        pending_items.insert(pending_items.size(), item_txn_t'{first_item, last_item, m});
    endtask

    // one search with a shared cursor, and a shared direction unless mixed_dir is set
    task automatic add_search(input int n, input bit mixed_dir);
        menu_item_t m;
        logic signed [14:0] px, py;
        logic [3:0] dir;
        px  = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
        py  = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
        dir = 4'($urandom_range(2, 9));
        for (int i = 0; i < n; i++)
        begin
            m.center_x      = rand_coord(px);
            m.center_y      = rand_coord(py);
            m.item_index    = 6'($urandom);
            m.is_selectable = ($urandom_range(0, 5) != 0);
            m.is_current    = ($urandom_range(0, 7) == 0);
            m.cursor_x      = px;
            m.cursor_y      = py;
            m.move_dir      = mixed_dir ? 4'($urandom) : dir;
            add_item(m,
                     (i == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 30) == 0),
                     i == n - 1);
        end
    endtask

    initial
    begin
        menu_item_t m;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        best_score    = 0;
        best_index    = 0;
        have_best     = 0;
        mismatches    = 0;
        src_gap       = 0;
        sink_gap      = 0;
        calm          = 0;
        hold_src      = 0;
        took_item     = 0;

        // directed: every direction from a shared cursor at the origin
        m = '0;
        m.is_selectable = 1'b1;
        for (int dir = 0; dir < 16; dir++)
        begin
            m.move_dir   = 4'(dir);
            m.center_x   = (dir % 3 == 0) ? 15'sd100 : -15'sd50;
            m.center_y   = (dir % 2 == 0) ? -15'sd100 : 15'sd70;
            m.item_index = 6'(dir);
            add_item(m, dir == 0, dir == 3 || dir == 9 || dir == 15);
        end
        // extreme corners, a zero distance, a current item and a tie
        m = '0;
        m.is_selectable = 1'b1;
        m.move_dir = DIR_DG6;
        m.cursor_x = -15'sd16384; m.cursor_y = 15'sd16383;
        m.center_x = 15'sd16383;  m.center_y = -15'sd16384; m.item_index = 6'd63;
        add_item(m, 1'b1, 1'b0);
        m.center_x = m.cursor_x;  m.center_y = m.cursor_y; m.item_index = 6'd1;
        add_item(m, 1'b0, 1'b0);
        m.center_x = 15'sd16383;  m.center_y = -15'sd16384; m.item_index = 6'd2;
        add_item(m, 1'b0, 1'b0);
        m.is_current = 1'b1; m.center_x = 15'sd0; m.item_index = 6'd3;
        add_item(m, 1'b0, 1'b1);
        // search without a first marker, one not-selectable item
        m = '0;
        m.move_dir = DIR_RIGHT; m.center_x = 15'sd10; m.item_index = 6'd5;
        add_item(m, 1'b0, 1'b1);

        // random searches, some with varied direction codes
        while (pending_items.size() < 420)
            add_search($urandom_range(1, 12), $urandom_range(0, 4) == 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pause the sender once until all picks have arrived
        wait (pending_items.size() < 250);
        hold_src = 1;
        wait (expected_picks.size() == 0);
        @(negedge clk);
        hold_src = 0;

        wait (pending_items.size() < 60);
        calm = 1;
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_picks.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_picks.size() == 0)
            $display("directional_nearest_item_select_test OK");
        else
            $display("directional_nearest_item_select_test NOT OK");
        $finish;
    end

    // sender: change at the falling edge, pop after an accepted transaction
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || took_item)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!hold_src && pending_items.size() > 0)
                begin
                    item_txn_t t;
                    t = pending_items.pop_front();
                    score_item(t);
                    s_axis_tdata  <= 72'(t.item);
                    s_axis_tuser  <= t.first_item;
                    s_axis_tlast  <= t.last_item;
                    s_axis_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        src_gap <= $urandom_range(1, 9);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // receiver stalls
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    sink_gap <= $urandom_range(1, 9);
            end
        end
    end

    // monitor: sample both channels at the rising edge
    always @(posedge clk)
    begin
        pick_t got;
        pick_t want;
        took_item <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = pick_t'{m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6]};
            if (expected_picks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d index=%0d score=%h",
                             got.found, got.winner_index, got.winner_score);
            end
            else
            begin
                want = expected_picks.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected found=%0d index=%0d score=%h, ",
                                  "got found=%0d index=%0d score=%h"},
                                 want.found, want.winner_index, want.winner_score,
                                 got.found, got.winner_index, got.winner_score);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("directional_nearest_item_select_test NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/dnis_pkg.sv
rtl/directional_nearest_item_select.sv
bench/directional_nearest_item_select_test.sv
